// ===== rtl/edsa_pkg.sv =====
`timescale 1ns / 1ps
package edsa_pkg;

   localparam int ID_W   = 16;
   localparam int SLOT_W = 24;

   localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TICK   = 1'b1
   } operation_type;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_ASSIGNED = 2'd1,
      KIND_DROPPED  = 2'd2,
      KIND_ACCEPTED = 2'd3
   } kind_type;

   typedef struct packed {
      operation_type     operation;
      logic [ID_W-1:0]   task_id;
      logic [SLOT_W-1:0] deadline;
   } req_payload_type;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   assigned_id;
      logic [SLOT_W-1:0] assigned_slot;
   } rsp_payload_type;

   typedef struct packed {
      logic [SLOT_W-1:0] deadline;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_ctl_type;

   function automatic logic goes_before(entry_type a, entry_type b);
      logic result;
      if (a.deadline != b.deadline) begin
         result = a.deadline < b.deadline;
      end else begin
         result = a.id < b.id;
      end
      return result;
   endfunction

endpackage

// ===== rtl/edsa_req_if.sv =====
`timescale 1ns / 1ps
interface edsa_req_if;
   logic                      valid;
   logic                      ready;
   edsa_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/edsa_rsp_if.sv =====
`timescale 1ns / 1ps
interface edsa_rsp_if;
   logic                      valid;
   logic                      ready;
   edsa_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/edsa_cell.sv =====
`timescale 1ns / 1ps
module edsa_cell (
   input  logic                   clock,
   input  edsa_pkg::cell_ctl_type ctl,
   input  logic                   occupied,
   input  edsa_pkg::entry_type    left_entry,
   input  logic                   left_precedes,
   input  edsa_pkg::entry_type    right_entry,
   output edsa_pkg::entry_type    entry,
   output logic                   precedes
);

   edsa_pkg::entry_type entry_ff;
   edsa_pkg::entry_type entry_in;

   assign precedes = !occupied || edsa_pkg::goes_before(ctl.item, entry_ff);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && precedes) begin
         entry_in = left_precedes ? left_entry : ctl.item;
      end else if (ctl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/earliest_deadline_slot_assigner_unit.sv =====
`timescale 1ns / 1ps
// Result: each response is registered in the cycle after its request beat is taken.
// Throughput: one request per cycle while the response side keeps up; the
// row of sorted cells shifts once per insert into a non-full queue or tick of a non-empty one, all cells together.
// Reset: synchronous, clears the pending count, slot counter and response valid;
// the cell contents need no clearing, since only occupied cells are read.
module earliest_deadline_slot_assigner_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   edsa_req_if.sink          req_bus,
   edsa_rsp_if.source        rsp_bus
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_W-1:0] DEPTH_MAX = COUNT_W'(QUEUE_DEPTH);

   logic [COUNT_W-1:0]             count_ff;
   logic [COUNT_W-1:0]             count_in;
   logic [edsa_pkg::SLOT_W-1:0]    slot_ff;
   logic [edsa_pkg::SLOT_W-1:0]    slot_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   edsa_pkg::rsp_payload_type      rsp_payload_ff;
   edsa_pkg::rsp_payload_type      rsp_payload_in;

   logic                           accept;
   logic                           full;
   logic                           empty;
   edsa_pkg::cell_ctl_type         ctl;
   edsa_pkg::entry_type            cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]         cell_precedes;

   assign req_bus.ready   = !rsp_valid_ff || rsp_bus.ready;
   assign accept          = req_bus.valid && req_bus.ready;
   assign full            = count_ff == DEPTH_MAX;
   assign empty           = count_ff == '0;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   assign ctl.item.deadline = req_bus.payload.deadline;
   assign ctl.item.id       = req_bus.payload.task_id;
   assign ctl.insert = accept && (req_bus.payload.operation == edsa_pkg::OP_INSERT) && !full;
   assign ctl.remove = accept && (req_bus.payload.operation == edsa_pkg::OP_TICK) && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      edsa_pkg::entry_type left_entry;
      edsa_pkg::entry_type right_entry;
      logic                left_precedes;

      if (i == 0) begin : g_head
         assign left_entry    = ctl.item;
         assign left_precedes = 1'b0;
      end else begin : g_body
         assign left_entry    = cell_entry[i-1];
         assign left_precedes = cell_precedes[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      edsa_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .occupied      (COUNT_W'(i) < count_ff),
         .left_entry    (left_entry),
         .left_precedes (left_precedes),
         .right_entry   (right_entry),
         .entry         (cell_entry[i]),
         .precedes      (cell_precedes[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.kind          = edsa_pkg::KIND_NONE;
         rsp_payload_in.assigned_id   = '0;
         rsp_payload_in.assigned_slot = '0;
         if (req_bus.payload.operation == edsa_pkg::OP_INSERT) begin
            rsp_payload_in.assigned_id = req_bus.payload.task_id;
            if (full) begin
               rsp_payload_in.kind = edsa_pkg::KIND_DROPPED;
            end else begin
               rsp_payload_in.kind = edsa_pkg::KIND_ACCEPTED;
               count_in            = count_ff + COUNT_W'(1);
            end
         end else begin
            if (!empty) begin
               rsp_payload_in.kind          = edsa_pkg::KIND_ASSIGNED;
               rsp_payload_in.assigned_id   = cell_entry[0].id;
               rsp_payload_in.assigned_slot = slot_ff;
               count_in                     = count_ff - COUNT_W'(1);
            end
            if (slot_ff != edsa_pkg::SLOT_MAX) begin
               slot_in = slot_ff + edsa_pkg::SLOT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule
